@@ rtl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, codes and the command/status bundles between the controller
// and the datapath of the ring-buffer deque.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Capacity of the ring buffer (2 to 31 entries).
  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int FILL_W = 5;

  // Command codes carried on the command port.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST_ALL   = 3'd4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_OUT,
    S_LIST
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_cmd;     // capture command and value of an accepted transaction
    logic    push_do;      // write the value and grow the queue
    logic    pop_do;       // read the end element and shrink the queue
    logic    list_start;   // read the front element and clear the walk index
    logic    list_next;    // advance the walk index and read the next element
    logic    emit_status;  // present a result with zero value and emit_code
    logic    emit_data;    // present a result with the read data
    status_t emit_code;
    logic    emit_last;
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_list;
    logic empty;
    logic full;
    logic list_last;
  } dq_stat_t;

  // Ring index plus offset, wrapped at the capacity.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] offset);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Ring index minus one, wrapped at the capacity.
  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] base);
    logic [PTR_W-1:0] res;
    if (base == '0) begin
      res = PTR_W'(DEPTH - 1);
    end else begin
      res = base - PTR_W'(1);
    end
    return res;
  endfunction

endpackage

@@ rtl/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences each transaction: decides on push, pop or list, then drives the
// datapath one step per cycle until the final result has been issued.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_cmd_t  cmd
);
  import dq_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_code = ST_OK;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_cmd = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        priority if (stat.is_push) begin
          cmd.emit_status = 1'b1;
          cmd.emit_last   = 1'b1;
          if (stat.full) begin
            cmd.emit_code = ST_FULL;
          end else begin
            cmd.push_do   = 1'b1;
            cmd.emit_code = ST_OK;
          end
        end else if (stat.is_pop) begin
          if (stat.empty) begin
            cmd.emit_status = 1'b1;
            cmd.emit_code   = ST_EMPTY;
            cmd.emit_last   = 1'b1;
          end else begin
            cmd.pop_do = 1'b1;
            state_next = S_POP_OUT;
          end
        end else if (stat.is_list) begin
          if (stat.empty) begin
            cmd.emit_status = 1'b1;
            cmd.emit_code   = ST_EMPTY;
            cmd.emit_last   = 1'b1;
          end else begin
            cmd.list_start = 1'b1;
            state_next     = S_LIST;
          end
        end else begin
          // Unused command codes are dropped without a result.
          state_next = S_IDLE;
        end
      end
      S_POP_OUT: begin
        cmd.emit_data = 1'b1;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      S_LIST: begin
        cmd.emit_data = 1'b1;
        cmd.emit_last = stat.list_last;
        if (stat.list_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.list_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/dq_datapath.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Holds the ring-buffer store, head pointer, element count, list walk index
// and the registered result outputs.
// ----------------------------------------------------------------------------
module dq_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dq_pkg::CMD_W-1:0]    command,
  input  logic signed [dq_pkg::DATA_W-1:0] value_in,
  input  dq_pkg::dq_cmd_t             cmd,
  output dq_pkg::dq_stat_t            stat,
  output logic signed [dq_pkg::DATA_W-1:0] value_out,
  output logic [1:0]                  status,
  output logic [dq_pkg::FILL_W-1:0]   fill_count,
  output logic                        last,
  output logic                        strobe
);
  import dq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [PTR_W-1:0]  idx;
  logic [PTR_W-1:0]  idx_inc;
  logic [PTR_W-1:0]  cnt_low;
  logic [PTR_W-1:0]  back_addr;
  logic [PTR_W-1:0]  wr_addr;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic              rd_en;
  logic              front_op;

  // Command decode for the controller.
  assign front_op       = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_POP_FRONT);
  assign stat.is_push   = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK);
  assign stat.is_pop    = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_BACK);
  assign stat.is_list   = (cmd_q == CMD_LIST_ALL);
  assign stat.empty     = (count == '0);
  assign stat.full      = (count >= CNT_W'(DEPTH));
  assign stat.list_last = ((CNT_W'(idx) + CNT_W'(1)) == count);

  // Ring addresses: a push uses the count only below the capacity, a pop from the back uses the count minus one.
  assign cnt_low   = count[PTR_W-1:0];
  assign back_addr = ring_add(head, cnt_low - PTR_W'(1));
  assign idx_inc   = idx + PTR_W'(1);

  // Pointer, count and memory port control.
  always_comb begin
    head_next  = head;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = ring_add(head, cnt_low);
    rd_en      = 1'b0;
    rd_addr    = head;
    if (cmd.push_do) begin
      wr_en      = 1'b1;
      count_next = count + CNT_W'(1);
      if (front_op) begin
        head_next = ring_dec(head);
        wr_addr   = ring_dec(head);
      end
    end
    if (cmd.pop_do) begin
      rd_en      = 1'b1;
      count_next = count - CNT_W'(1);
      if (front_op) begin
        head_next = ring_add(head, PTR_W'(1));
      end else begin
        rd_addr = back_addr;
      end
    end
    if (cmd.list_start) begin
      rd_en = 1'b1;
    end
    if (cmd.list_next) begin
      rd_en   = 1'b1;
      rd_addr = ring_add(head, idx_inc);
    end
  end

  // Element store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_q;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Captured transaction payload and list walk index.
  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      cmd_q   <= command;
      value_q <= value_in;
    end
    if (cmd.list_start) begin
      idx <= '0;
    end else if (cmd.list_next) begin
      idx <= idx_inc;
    end
  end

  // Queue state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_status | cmd.emit_data;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      value_out <= '0;
      status    <= cmd.emit_code;
    end else if (cmd.emit_data) begin
      value_out <= rdata;
      status    <= ST_OK;
    end
    if (cmd.emit_status || cmd.emit_data) begin
      fill_count <= FILL_W'(count_next);
      last       <= cmd.emit_last;
    end
  end

endmodule

@@ rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit values in a ring buffer, with push and pop
// at both ends and a front-to-back listing of all elements.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ---------------------------------------
//  command   start & !busy             command, value_in
//  result    strobe (one cycle each)   value_out, status, fill_count, last
//
// A push issues its result from the execute state; a pop first passes through
// a further state for the registered read of the element store. A list of N
// elements gives one result per cycle once its front element has been read,
// so the store's single read port sets its length. busy is high from the cycle
// after acceptance until the final result is issued; a new transaction may
// be accepted while that last result is on the ports. Reset empties the
// queue at once; no clearing pass is needed. The receiver cannot stall.
//
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [dq_pkg::CMD_W-1:0]          command,
  input  logic signed [dq_pkg::DATA_W-1:0]  value_in,
  output logic signed [dq_pkg::DATA_W-1:0]  value_out,
  output logic [1:0]                        status,
  output logic [dq_pkg::FILL_W-1:0]         fill_count,
  output logic                              last,
  output logic                              strobe
);
  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  // Transaction sequencer.
  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Store, pointers and result registers.
  dq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .value_in   (value_in),
    .cmd        (cmd),
    .stat       (stat),
    .value_out  (value_out),
    .status     (status),
    .fill_count (fill_count),
    .last       (last),
    .strobe     (strobe)
  );

endmodule
